[hdl/variable_partition_fit_allocator_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the partition allocator checker
// Clocked, reset-qualified and reset-time concurrent assertion wrappers.
// ----------------------------------------------------------------------------
`ifndef VARIABLE_PARTITION_FIT_ALLOCATOR_ASSERT_SVH
`define VARIABLE_PARTITION_FIT_ALLOCATOR_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define VPFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define VPFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/vpfa_pkg.sv]
// ----------------------------------------------------------------------------
// vpfa_pkg
// Shared codes and widths of the variable partition allocator.
// ----------------------------------------------------------------------------
package vpfa_pkg;

  localparam int FREE_W     = 23;
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_USER_W = 3;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ALLOC  = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  localparam logic [1:0] POL_SMALLEST = 2'd1;
  localparam logic [1:0] POL_LARGEST  = 2'd2;

  localparam logic [2:0] ST_LOADED   = 3'd0;
  localparam logic [2:0] ST_GRANTED  = 3'd1;
  localparam logic [2:0] ST_NO_FIT   = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_FINISHED = 3'd4;

endpackage

[hdl/vpfa_cell.sv]
// ----------------------------------------------------------------------------
// vpfa_cell
// One storage cell of a rotating table; takes its neighbor's entry on shift.
// ----------------------------------------------------------------------------
module vpfa_cell #(
  parameter int W = 17
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] q;

  always_ff @(posedge clk) begin
    if (en) begin
      q <= din;
    end
  end

  assign dout = q;

endmodule

[hdl/vpfa_ring.sv]
// ----------------------------------------------------------------------------
// vpfa_ring
// Chain of cells; each shift moves every entry one place toward the head.
// ----------------------------------------------------------------------------
module vpfa_ring #(
  parameter int DEPTH = 128,
  parameter int W     = 17
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] tail,
  output logic [W-1:0] head,
  output logic [W-1:0] second
);

  logic [W-1:0] q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [W-1:0] d;
    if (i == DEPTH - 1) begin : g_last
      assign d = tail;
    end else begin : g_mid
      assign d = q[i+1];
    end
    vpfa_cell #(.W(W)) u_cell (.clk(clk), .en(en), .din(d), .dout(q[i]));
  end

  assign head = q[0];

  if (DEPTH > 1) begin : g_two
    assign second = q[1];
  end else begin : g_one
    assign second = q[0];
  end

endmodule

[hdl/variable_partition_fit_allocator.sv]
// ----------------------------------------------------------------------------
// variable_partition_fit_allocator: first / smallest / largest fit allocator
// Load and finish each take one pass; allocate takes a scan pass, then an
// apply pass (or a refusal pass when the refusal is recorded);
// one item at a time, each pass rotating a cell chain once.
// rst clears counts and policy.
// ----------------------------------------------------------------------------
module variable_partition_fit_allocator #(
  parameter int MAX_PARTITIONS = 128,
  parameter int MAX_REFUSED    = 128,
  parameter int SIZE_BITS      = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // tdata: size[15:0], filled[16], zero pad
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [vpfa_pkg::IN_DATA_W-1:0]   s_tdata,
  // tuser: opcode[1:0]
  input  logic [vpfa_pkg::IN_USER_W-1:0]   s_tuser,
  // tdata: position[6:0], external_fragmentation[22:7], free_space[45:23],
  //        partition_count[53:46], zero pad
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [vpfa_pkg::OUT_DATA_W-1:0]  m_tdata,
  // tuser: status[2:0]
  output logic [vpfa_pkg::OUT_USER_W-1:0]  m_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_data
);

  import vpfa_pkg::*;

  localparam int MAXD = (MAX_PARTITIONS > MAX_REFUSED) ? MAX_PARTITIONS : MAX_REFUSED;
  localparam int CW   = $clog2(MAXD + 1) + 1;
  localparam int PW   = $clog2(MAX_PARTITIONS);
  localparam int CNW  = $clog2(MAX_PARTITIONS + 1);
  localparam int RCW  = $clog2(MAX_REFUSED + 1);
  localparam int SB   = SIZE_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_SCAN, S_APPLY, S_REF, S_FIN, S_PUSH
  } state_t;

  state_t          state;
  logic [CW-1:0]   k;
  logic [1:0]      policy;
  logic [CNW-1:0]  count;
  logic [RCW-1:0]  rcount;
  logic [FREE_W-1:0] free_total;

  // per-item registers
  logic [SB-1:0]   req;
  logic            fil;
  logic            found;
  logic [PW-1:0]   pick;
  logic [SB-1:0]   best;
  logic            merge_f;
  logic            full_f;
  logic            ins_act;
  logic            lmerged;
  logic [SB-1:0]   carry_s;
  logic            carry_u;
  logic [SB-1:0]   fbest;
  logic [2:0]      p_status;
  logic [PW-1:0]   p_pos;
  logic [SB-1:0]   p_frag;

  // table rings
  logic [SB:0]     p_tail, p_head, p_second;
  logic [SB-1:0]   r_tail, r_head, r_unused;
  logic            p_en, r_en;

  logic [SB-1:0]   head_s, second_s;
  logic            head_u, second_u;
  assign head_s   = p_head[SB-1:0];
  assign head_u   = p_head[SB];
  assign second_s = p_second[SB-1:0];
  assign second_u = p_second[SB];

  vpfa_ring #(.DEPTH(MAX_PARTITIONS), .W(SB + 1)) u_parts (
    .clk(clk), .en(p_en), .tail(p_tail), .head(p_head), .second(p_second)
  );

  vpfa_ring #(.DEPTH(MAX_REFUSED), .W(SB)) u_refused (
    .clk(clk), .en(r_en), .tail(r_tail), .head(r_head), .second(r_unused)
  );

  assign p_en = (state == S_LOAD) || (state == S_SCAN) || (state == S_APPLY);
  assign r_en = (state == S_REF) || (state == S_FIN);

  // handshakes
  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // size field cut or widened to the table width
  logic [63:0]   in_w;
  logic [SB-1:0] in_size;
  assign in_w    = 64'(s_tdata[15:0]);
  assign in_size = in_w[SB-1:0];

  // pass position compares
  logic p_last, r_last, in_tab, at_n, at_nm1, at_pick, at_pick1, below_n1, tab_full;
  assign p_last   = (k == CW'(MAX_PARTITIONS - 1));
  assign r_last   = (k == CW'(MAX_REFUSED - 1));
  assign in_tab   = (k < CW'(count));
  assign at_n     = (k == CW'(count));
  assign at_nm1   = ((k + 1'b1) == CW'(count));
  assign at_pick  = (k == CW'(pick));
  assign at_pick1 = (k == (CW'(pick) + 1'b1));
  assign below_n1 = ((k + 1'b1) < CW'(count));
  assign tab_full = (count >= CNW'(MAX_PARTITIONS));

  // size sums with overflow detect
  logic [SB:0]   sum_load, sum_next, sum_head;
  logic [SB-1:0] rest;
  assign rest     = best - req;
  assign sum_load = {1'b0, head_s} + {1'b0, req};
  assign sum_next = {1'b0, second_s} + {1'b0, rest};
  assign sum_head = {1'b0, head_s} + {1'b0, rest};

  // load: merge into the free last entry
  logic load_merge;
  assign load_merge = (state == S_LOAD) && !fil && at_nm1 && !head_u && !sum_load[SB];

  // apply: decide what the remainder does when the pick reaches the head
  logic apply_now, dec_merge, dec_full, dec_ins;
  assign apply_now = (state == S_APPLY) && at_pick && (rest != '0);
  assign dec_merge = apply_now && below_n1 && !second_u && !sum_next[SB];
  assign dec_full  = apply_now && !dec_merge && tab_full;
  assign dec_ins   = apply_now && !dec_merge && !tab_full;

  // scan: fit test and policy
  logic fit, take;
  always_comb begin
    fit  = (state == S_SCAN) && in_tab && !head_u && (head_s >= req);
    take = 1'b0;
    case (policy)
      POL_SMALLEST: take = fit && (!found || head_s < best);
      POL_LARGEST:  take = fit && (!found || head_s > best);
      default:      take = fit && !found;
    endcase
  end

  // finish: largest refused size covered by the free space
  logic fin_take;
  assign fin_take = (state == S_FIN) && (k < CW'(rcount)) &&
                    (64'(r_head) <= 64'(free_total)) && (r_head > fbest);

  // tail of the partition ring: rewrite the entry leaving the head
  always_comb begin
    p_tail = p_head;
    if (ins_act) begin
      p_tail = {carry_u, carry_s};
    end else begin
      case (state)
        S_LOAD: begin
          if (load_merge) begin
            p_tail = {1'b0, sum_load[SB-1:0]};
          end else if (at_n && !lmerged && !tab_full) begin
            p_tail = {fil, req};
          end
        end
        S_APPLY: begin
          if (at_pick && !dec_full) begin
            p_tail = {1'b1, (rest == '0) ? head_s : req};
          end else if (at_pick1 && merge_f) begin
            p_tail = {1'b0, sum_head[SB-1:0]};
          end
        end
        default: p_tail = p_head;
      endcase
    end
  end

  assign r_tail = ((state == S_REF) && (k == CW'(rcount))) ? req : r_head;

  logic [63:0] req_w, pos_w, frag_w, cnt_w;
  assign req_w  = 64'(req);
  assign pos_w  = 64'(p_pos);
  assign frag_w = 64'(p_frag);
  assign cnt_w  = 64'(count);

  logic          grant_ins;
  logic [SB-1:0] fin_best;
  assign grant_ins = ins_act || dec_ins;
  assign fin_best  = fin_take ? r_head : fbest;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      k          <= '0;
      policy     <= '0;
      count      <= '0;
      rcount     <= '0;
      free_total <= '0;
      m_tvalid   <= 1'b0;
      ins_act    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        policy <= cfg_data;
      end
      // drop the taken beat unless a new one is loaded in the same cycle
      if (m_tvalid && m_tready && (state != S_PUSH)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req     <= in_size;
            fil     <= s_tdata[16];
            k       <= '0;
            found   <= 1'b0;
            best    <= '0;
            merge_f <= 1'b0;
            full_f  <= 1'b0;
            lmerged <= 1'b0;
            fbest   <= '0;
            p_pos   <= '0;
            p_frag  <= '0;
            case (s_tuser)
              OP_LOAD:   state <= S_LOAD;
              OP_ALLOC:  state <= S_SCAN;
              OP_FINISH: state <= S_FIN;
              default:   state <= S_IDLE;  // drop the unknown opcode
            endcase
          end
        end
        S_LOAD: begin
          if (load_merge) begin
            lmerged <= 1'b1;
          end
          if (p_last) begin
            k <= '0;
            if (lmerged || load_merge || !tab_full) begin
              p_status <= ST_LOADED;
              if (!(lmerged || load_merge)) begin
                count <= count + 1'b1;
              end
              if (!fil) begin
                free_total <= free_total + req_w[FREE_W-1:0];
              end
            end else begin
              p_status <= ST_FULL;
            end
            state <= S_PUSH;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_SCAN: begin
          if (take) begin
            found <= 1'b1;
            pick  <= k[PW-1:0];
            best  <= head_s;
          end
          if (p_last) begin
            k <= '0;
            if (found || take) begin
              state <= S_APPLY;
            end else begin
              p_status <= ST_NO_FIT;
              state    <= (rcount < RCW'(MAX_REFUSED)) ? S_REF : S_PUSH;
            end
          end else begin
            k <= k + 1'b1;
          end
        end
        S_APPLY: begin
          // hold back every entry after the pick by one place
          if (ins_act) begin
            carry_s <= head_s;
            carry_u <= head_u;
          end else if (dec_ins) begin
            carry_s <= rest;
            carry_u <= 1'b0;
            ins_act <= 1'b1;
          end
          if (dec_merge) begin
            merge_f <= 1'b1;
          end
          if (dec_full) begin
            full_f <= 1'b1;
          end
          if (p_last) begin
            k       <= '0;
            ins_act <= 1'b0;
            if (full_f || dec_full) begin
              p_status <= ST_FULL;
            end else begin
              p_status   <= ST_GRANTED;
              p_pos      <= pick;
              free_total <= free_total - req_w[FREE_W-1:0];
              if (grant_ins) begin
                count <= count + 1'b1;
              end
            end
            state <= S_PUSH;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_REF: begin
          if (r_last) begin
            k      <= '0;
            rcount <= rcount + 1'b1;
            state  <= S_PUSH;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_FIN: begin
          if (fin_take) begin
            fbest <= r_head;
          end
          if (r_last) begin
            k          <= '0;
            p_frag     <= fin_best;
            p_status   <= ST_FINISHED;
            count      <= '0;
            rcount     <= '0;
            free_total <= '0;
            state      <= S_PUSH;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_PUSH: begin
          // advance only once the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= p_status;
            m_tdata  <= {2'b00, cnt_w[7:0], free_total, frag_w[15:0], pos_w[6:0]};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/vpfa_checker.sv]
// ----------------------------------------------------------------------------
// vpfa_checker
// Port-level checks of the allocator's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "variable_partition_fit_allocator_assert.svh"

module vpfa_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [vpfa_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [vpfa_pkg::OUT_USER_W-1:0] m_tuser
);

  import vpfa_pkg::*;

  `VPFA_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result beat changed")
  `VPFA_ASSERT(a_pos, m_tvalid && (m_tuser != ST_GRANTED) |-> (m_tdata[6:0] == 7'd0), "position set on a non-grant beat")
  `VPFA_ASSERT(a_frag, m_tvalid && (m_tuser != ST_FINISHED) |-> (m_tdata[22:7] == 16'd0), "fragmentation set on a non-finish beat")
  `VPFA_ASSERT(a_clear, m_tvalid && (m_tuser == ST_FINISHED) |-> (m_tdata[53:23] == 31'd0), "table not cleared on finish")
  `VPFA_ASSERT_ALWAYS(a_rst, rst |=> !m_tvalid, "result beat valid after reset")

endmodule

bind variable_partition_fit_allocator vpfa_checker u_vpfa_checker (.*);
